// ===== src/bwrh_pkg.sv =====
`default_nettype none
package bwrh_pkg;
    localparam int unsigned PIXEL_W = 19;
    localparam int unsigned WALL_W  = 3;
    localparam int unsigned COORD_W = 16;
    localparam logic [WALL_W-1:0] WALL_LEFT   = 3'd0;
    localparam logic [WALL_W-1:0] WALL_RIGHT  = 3'd1;
    localparam logic [WALL_W-1:0] WALL_BOTTOM = 3'd2;
    localparam logic [WALL_W-1:0] WALL_TOP    = 3'd3;
    localparam logic [WALL_W-1:0] WALL_BACK   = 3'd4;
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MAX_X = 3'd1;
    localparam logic [2:0] REG_MIN_Y = 3'd2;
    localparam logic [2:0] REG_MAX_Y = 3'd3;
    localparam logic [2:0] REG_MAX_Z = 3'd4;
    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [WALL_W-1:0] t_wall;
    typedef logic signed [COORD_W-1:0] t_coord;
endpackage
`default_nettype wire

// ===== src/bwrh_if.sv =====
`default_nettype none
interface bwrh_pix_if;
    logic valid;
    logic ready;
    bwrh_pkg::t_pixel pixel_index;
    modport source (output valid, output pixel_index, input ready);
    modport sink (input valid, input pixel_index, output ready);
endinterface

interface bwrh_wall_if;
    logic valid;
    logic ready;
    bwrh_pkg::t_wall wall_id;
    modport source (output valid, output wall_id, input ready);
    modport sink (input valid, input wall_id, output ready);
endinterface

interface bwrh_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/box_wall_ray_hit.sv =====
`default_nettype none
// A pixel flows through the front splitter, the queue and the wall comparator in that order.
// Throughput: one pixel per cycle unless o_wall stalls; front and back fully pipelined.
// Synchronous active-low reset empties every stage and the queue and sets the walls to
// -1.0/+1.0 on each side and the back wall to +1.0.
module box_wall_ray_hit #(
    parameter int unsigned IMAGE_WIDTH  = 640,
    parameter int unsigned IMAGE_HEIGHT = 480
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bwrh_pix_if.sink  i_pix,
    bwrh_cfg_if.sink  i_cfg,
    bwrh_wall_if.source o_wall
);
    import bwrh_pkg::*;
    localparam int unsigned SW = PIXEL_W + 2;

    t_coord r_min_x, r_max_x, r_min_y, r_max_y, r_max_z;
    logic w_fv, w_fr, w_qv, w_qr;
    logic signed [SW-1:0] w_xs, w_ys;
    logic [2*SW-1:0] w_qd;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= -16'sd256;
            r_max_x <= 16'sd256;
            r_min_y <= -16'sd256;
            r_max_y <= 16'sd256;
            r_max_z <= 16'sd256;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_X: r_min_x <= i_cfg.data;
                REG_MAX_X: r_max_x <= i_cfg.data;
                REG_MIN_Y: r_min_y <= i_cfg.data;
                REG_MAX_Y: r_max_y <= i_cfg.data;
                REG_MAX_Z: r_max_z <= i_cfg.data;
                default: ;
            endcase
        end
    end

    bwrh_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT), .SW(SW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_pix.valid), .o_ready(i_pix.ready), .i_pixel(i_pix.pixel_index),
        .o_valid(w_fv), .i_ready(w_fr), .o_xs(w_xs), .o_ys(w_ys)
    );

    bwrh_fifo #(.DW(2*SW)) u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_ready(w_fr), .i_data({w_xs, w_ys}),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qd)
    );

    bwrh_back #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT), .SW(SW)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr),
        .i_xs(w_qd[2*SW-1:SW]), .i_ys(w_qd[SW-1:0]),
        .i_min_x(r_min_x), .i_max_x(r_max_x), .i_min_y(r_min_y), .i_max_y(r_max_y),
        .i_max_z(r_max_z),
        .o_valid(o_wall.valid), .i_ready(o_wall.ready), .o_wall(o_wall.wall_id)
    );
endmodule
`default_nettype wire

// ===== src/bwrh_front.sv =====
`default_nettype none
// Splits the pixel index into row and column: one row subtraction step per cycle is not
// needed, the row is found by multiplying by a reciprocal and correcting once.
module bwrh_front #(
    parameter int unsigned IMAGE_WIDTH  = 640,
    parameter int unsigned IMAGE_HEIGHT = 480,
    parameter int unsigned SW = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire bwrh_pkg::t_pixel i_pixel,
    output logic o_valid,
    input  wire logic i_ready,
    output logic signed [SW-1:0] o_xs,
    output logic signed [SW-1:0] o_ys
);
    import bwrh_pkg::*;
    localparam int unsigned RW = PIXEL_W;
    localparam int unsigned SH = 2 * PIXEL_W;
    localparam longint unsigned RECIP = ((64'd1 << SH) / IMAGE_WIDTH) + 64'd1;
    localparam int unsigned RCW = SH + 2;

    logic r_v1, r_v2;
    t_pixel r_p1;
    logic [RW-1:0] r_q1;
    logic [RW+RCW-1:0] w_prod;
    logic [RW-1:0] w_q;
    logic [RW+12:0] w_rem;
    logic [RW-1:0] w_row;
    logic [12:0] w_col;
    logic signed [SW-1:0] r_xs, r_ys;
    logic w_adv1, w_adv2;

    assign w_adv2 = !r_v2 || i_ready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign w_prod = RW'(i_pixel) * (RW+RCW)'(RECIP);
    assign w_q = w_prod[SH +: RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
        if (w_adv1) begin
            r_p1 <= i_pixel;
            r_q1 <= w_q;
        end
        if (w_adv2) begin
            r_xs <= SW'($signed({2'b0, w_col, 1'b0})) - SW'(IMAGE_WIDTH - 1);
            r_ys <= SW'(IMAGE_HEIGHT - 1) - SW'($signed({1'b0, w_row, 1'b0}));
        end
    end

    always_comb begin
        w_rem = (RW+13)'(r_p1) - (RW+13)'(r_q1) * (RW+13)'(IMAGE_WIDTH);
        w_row = r_q1;
        if ($signed(w_rem) < 0) begin
            w_rem = w_rem + (RW+13)'(IMAGE_WIDTH);
            w_row = r_q1 - RW'(1);
        end
        w_col = w_rem[12:0];
    end

    assign o_valid = r_v2;
    assign o_xs = r_xs;
    assign o_ys = r_ys;
endmodule
`default_nettype wire

// ===== src/bwrh_fifo.sv =====
`default_nettype none
module bwrh_fifo #(
    parameter int unsigned DW = 30
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire logic [DW-1:0] i_data,
    output logic o_valid,
    input  wire logic i_ready,
    output logic [DW-1:0] o_data
);
    logic [DW-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ===== src/bwrh_back.sv =====
`default_nettype none
// Forms the distance fractions, compares the walls in two registered levels.
module bwrh_back #(
    parameter int unsigned IMAGE_WIDTH  = 640,
    parameter int unsigned IMAGE_HEIGHT = 480,
    parameter int unsigned SW = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire logic signed [SW-1:0] i_xs,
    input  wire logic signed [SW-1:0] i_ys,
    input  wire bwrh_pkg::t_coord i_min_x,
    input  wire bwrh_pkg::t_coord i_max_x,
    input  wire bwrh_pkg::t_coord i_min_y,
    input  wire bwrh_pkg::t_coord i_max_y,
    input  wire bwrh_pkg::t_coord i_max_z,
    output logic o_valid,
    input  wire logic i_ready,
    output bwrh_pkg::t_wall o_wall
);
    import bwrh_pkg::*;
    localparam int unsigned NW = 32;
    localparam int unsigned PW = 64;
    typedef logic signed [NW-1:0] t_num;
    typedef logic signed [PW-1:0] t_prod;

    logic r_v1, r_v2, r_v3;
    logic w_a1, w_a2, w_a3;
    t_num r_n [5];
    t_num r_d [4];
    logic [3:0] r_ok;
    t_num r_bn [2];
    t_num r_bd [2];
    t_wall r_bi [2];
    logic [1:0] r_bh;
    t_num r_zn;
    t_wall r_res;

    assign w_a3 = !r_v3 || i_ready;
    assign w_a2 = !r_v2 || w_a3;
    assign w_a1 = !r_v1 || w_a2;
    assign o_ready = w_a1;

    function automatic logic less(input t_num n1, input t_num d1, input t_num n2,
                                  input t_num d2);
        t_prod a, b;
        a = PW'(n1) * PW'(d2);
        b = PW'(n2) * PW'(d1);
        return $signed(a) < $signed(b);
    endfunction

    logic [1:0] w_h;
    t_num w_n [2];
    t_num w_d [2];
    t_wall w_i [2];
    t_wall w_res;

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            w_h[g] = r_ok[2*g] || r_ok[2*g+1];
            w_n[g] = r_n[2*g];
            w_d[g] = r_d[2*g];
            w_i[g] = t_wall'(2*g);
            if (r_ok[2*g+1] && (!r_ok[2*g] ||
                less(r_n[2*g+1], r_d[2*g+1], r_n[2*g], r_d[2*g]))) begin
                w_n[g] = r_n[2*g+1];
                w_d[g] = r_d[2*g+1];
                w_i[g] = t_wall'(2*g+1);
            end
        end
    end

    logic w_sel1, w_z0, w_z1;
    always_comb begin
        w_sel1 = r_bh[1] && (!r_bh[0] || less(r_bn[1], r_bd[1], r_bn[0], r_bd[0]));
        w_z0 = less(r_zn, NW'(1), r_bn[0], r_bd[0]);
        w_z1 = less(r_zn, NW'(1), r_bn[1], r_bd[1]);
        w_res = WALL_BACK;
        if (w_sel1) begin
            if (!w_z1) w_res = r_bi[1];
        end else if (r_bh[0]) begin
            if (!w_z0) w_res = r_bi[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_a1) r_v1 <= i_valid;
            if (w_a2) r_v2 <= r_v1;
            if (w_a3) r_v3 <= r_v2;
        end
        if (w_a1) begin
            r_n[0] <= -(NW'(i_min_x) * NW'(IMAGE_WIDTH - 1));
            r_d[0] <= -NW'(i_xs);
            r_ok[0] <= i_xs < 0;
            r_n[1] <= NW'(i_max_x) * NW'(IMAGE_WIDTH - 1);
            r_d[1] <= NW'(i_xs);
            r_ok[1] <= i_xs > 0;
            r_n[2] <= -(NW'(i_min_y) * NW'(IMAGE_HEIGHT - 1));
            r_d[2] <= -NW'(i_ys);
            r_ok[2] <= i_ys < 0;
            r_n[3] <= NW'(i_max_y) * NW'(IMAGE_HEIGHT - 1);
            r_d[3] <= NW'(i_ys);
            r_ok[3] <= i_ys > 0;
            r_n[4] <= NW'(i_max_z) * NW'(2);
        end
        if (w_a2) begin
            r_bn <= w_n;
            r_bd <= w_d;
            r_bi <= w_i;
            r_bh <= w_h;
            r_zn <= r_n[4];
        end
        if (w_a3) r_res <= w_res;
    end

    assign o_valid = r_v3;
    assign o_wall = r_res;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bwrh_pkg::*;

    localparam int IMG_W = 640;
    localparam int IMG_H = 480;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        bit is_cfg;
        logic [2:0] index;
        logic [15:0] data;
        t_pixel pixel;
    } t_job;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bwrh_pix_if pix ();
    bwrh_cfg_if cfg ();
    bwrh_wall_if wall ();

    box_wall_ray_hit #(.IMAGE_WIDTH(IMG_W), .IMAGE_HEIGHT(IMG_H)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pix(pix.sink),
        .i_cfg(cfg.sink),
        .o_wall(wall.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_job job_q[$];
    t_wall wall_expected_q[$];
    longint wall_min_x = -256, wall_max_x = 256, wall_min_y = -256;
    longint wall_max_y = 256, wall_max_z = 256;
    int mismatches = 0;
    int walls_seen = 0;
    int cfg_writes = 0;
    int pixels_sent = 0;
    int idle_cycles = 0;
    int drv_gap = 0;
    int mon_gap = 0;
    int hold_off = 0;
    bit stim_done = 1'b0;
    bit drain_wait = 1'b0;
    bit timed_out = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_wall nearest_wall(t_pixel p);
        longint col, row, wm1, hm1, xs, ys, bn, bd;
        bit have;
        t_wall bid;
        longint n[5];
        longint d[5];
        bit ok[5];
        col = longint'(p) % IMG_W;
        row = longint'(p) / IMG_W;
        wm1 = IMG_W - 1;
        hm1 = IMG_H - 1;
        xs = 2 * col - wm1;
        ys = hm1 - 2 * row;
        ok[0] = xs < 0; n[0] = -wall_min_x * wm1; d[0] = -xs;
        ok[1] = xs > 0; n[1] = wall_max_x * wm1;  d[1] = xs;
        ok[2] = ys < 0; n[2] = -wall_min_y * hm1; d[2] = -ys;
        ok[3] = ys > 0; n[3] = wall_max_y * hm1;  d[3] = ys;
        ok[4] = 1'b1;   n[4] = 2 * wall_max_z;    d[4] = 1;
        have = 1'b0;
        bn = 0;
        bd = 1;
        bid = WALL_BACK;
        for (int k = 0; k < 5; k++) begin
            if (ok[k] && (!have || n[k] * bd < bn * d[k])) begin
                have = 1'b1;
                bn = n[k];
                bd = d[k];
                bid = t_wall'(k);
            end
        end
        return bid;
    endfunction

    task automatic apply_reg(logic [2:0] idx, logic [15:0] v);
        longint s;
        s = longint'($signed(v));
        case (idx)
            REG_MIN_X: wall_min_x = s;
            REG_MAX_X: wall_max_x = s;
            REG_MIN_Y: wall_min_y = s;
            REG_MAX_Y: wall_max_y = s;
            REG_MAX_Z: wall_max_z = s;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(t_wall got, t_wall want, string what);
        mismatches++;
        $display("[%0t] wall_id mismatch (%s): got %0d expected %0d", $realtime, what, got,
                 want);
    endtask

    task automatic push_pixel(t_pixel p);
        t_job j;
        j.is_cfg = 1'b0;
        j.index = REG_MIN_X;
        j.data = '0;
        j.pixel = p;
        job_q.push_back(j);
    endtask

    task automatic push_reg(logic [2:0] idx, logic [15:0] v);
        t_job j;
        j.is_cfg = 1'b1;
        j.index = idx;
        j.data = v;
        j.pixel = '0;
        job_q.push_back(j);
    endtask

    task automatic push_walls(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [15:0] d, logic [15:0] e);
        push_reg(REG_MIN_X, a);
        push_reg(REG_MAX_X, b);
        push_reg(REG_MIN_Y, c);
        push_reg(REG_MAX_Y, d);
        push_reg(REG_MAX_Z, e);
    endtask

    function automatic t_pixel rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_pixel'($urandom_range(0, 524287));
        if (r == 1) return t_pixel'(($urandom_range(0, IMG_H - 1)) * IMG_W + 319 +
                                    $urandom_range(0, 1));
        if (r == 2) return t_pixel'((239 + $urandom_range(0, 1)) * IMG_W +
                                    $urandom_range(0, IMG_W - 1));
        return t_pixel'($urandom_range(0, IMG_W * IMG_H - 1));
    endfunction

    initial begin
        push_pixel(t_pixel'(0));
        push_pixel(t_pixel'(IMG_W - 1));
        push_pixel(t_pixel'(IMG_W * IMG_H - 1));
        push_pixel(t_pixel'((IMG_H - 1) * IMG_W));
        push_pixel(t_pixel'(240 * IMG_W + 320));
        push_pixel(t_pixel'(239 * IMG_W + 319));
        push_pixel(t_pixel'(100 * IMG_W + 319));
        push_pixel(t_pixel'(239 * IMG_W + 10));
        push_pixel(t_pixel'(IMG_W * IMG_H));
        push_pixel(t_pixel'(524287));
        push_pixel(t_pixel'(10 * IMG_W + 300));
        push_walls(16'h0100, 16'hFF00, 16'h0080, 16'hFF80, 16'hFE00);
        push_pixel(t_pixel'(5 * IMG_W + 5));
        push_pixel(t_pixel'(400 * IMG_W + 600));
        push_pixel(t_pixel'(240 * IMG_W + 319));
        push_walls(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        push_pixel(t_pixel'(0));
        push_pixel(t_pixel'(IMG_W * IMG_H - 1));
        push_pixel(t_pixel'(524287));
        push_reg(3'd5, 16'h1234);
        push_reg(3'd7, 16'hFFFF);
        push_pixel(t_pixel'(123456));
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: push_walls(16'hFF00, 16'h0100, 16'hFF00, 16'h0100, 16'h0100);
                1: push_walls(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
                default: push_walls(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
            endcase
            for (int k = 0; k < 92; k++) begin
                push_pixel(rand_pixel());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            pix.pixel_index <= '0;
            cfg.valid <= 1'b0;
            cfg.index <= '0;
            cfg.data <= '0;
            drain_wait <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                wall_expected_q.push_back(nearest_wall(pix.pixel_index));
                pixels_sent++;
            end
            if (cfg.valid && cfg.ready) begin
                apply_reg(cfg.index, cfg.data);
                cfg_writes++;
            end
            if ((pix.valid && !pix.ready) || (cfg.valid && !cfg.ready)) begin
            end else if (drv_gap > 0) begin
                pix.valid <= 1'b0;
                cfg.valid <= 1'b0;
                drv_gap--;
            end else if (job_q.size() == 0) begin
                pix.valid <= 1'b0;
                cfg.valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (job_q[0].is_cfg || (pixels_sent == 400 && !drain_wait)) begin
                pix.valid <= 1'b0;
                cfg.valid <= 1'b0;
                if (wall_expected_q.size() == 0 && !(pix.valid && pix.ready)) begin
                    if (hold_off < 10) begin
                        hold_off++;
                    end else if (!job_q[0].is_cfg) begin
                        drain_wait <= 1'b1;
                        hold_off = 0;
                    end else begin
                        hold_off = 0;
                        cfg.valid <= 1'b1;
                        cfg.index <= job_q[0].index;
                        cfg.data <= job_q[0].data;
                        void'(job_q.pop_front());
                    end
                end else begin
                    hold_off = 0;
                end
            end else begin
                cfg.valid <= 1'b0;
                pix.valid <= 1'b1;
                pix.pixel_index <= job_q[0].pixel;
                void'(job_q.pop_front());
                drv_gap = (pixels_sent > 200 && pixels_sent < 260) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wall.ready <= 1'b0;
        end else begin
            if (wall.valid && wall.ready) begin
                walls_seen++;
                if (wall_expected_q.size() == 0) begin
                    report_mismatch(wall.wall_id, WALL_BACK, "unexpected transaction");
                end else if (wall.wall_id !== wall_expected_q[0]) begin
                    report_mismatch(wall.wall_id, wall_expected_q.pop_front(), "value");
                end else begin
                    void'(wall_expected_q.pop_front());
                end
            end
            if (mon_gap > 0) begin
                wall.ready <= 1'b0;
                mon_gap--;
            end else begin
                wall.ready <= 1'b1;
                mon_gap = (walls_seen > 500 && walls_seen < 560) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (wall.valid && wall.ready) ||
            (cfg.valid && cfg.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
            end
        end
    end

    initial begin
        pix.valid = 1'b0;
        pix.pixel_index = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        wall.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait ((stim_done && wall_expected_q.size() == 0) || timed_out);
        if (!timed_out) begin
            repeat (20) @(posedge i_clk);
        end
        $display("Covered %0d pixels and %0d register writes; %0d walls checked.",
                 pixels_sent, cfg_writes, walls_seen);
        if (timed_out) begin
            $display("Watchdog expired with %0d results outstanding.",
                     wall_expected_q.size());
            $display("box_wall_ray_hit regression: fail");
        end else if (mismatches == 0 && wall_expected_q.size() == 0) begin
            $display("box_wall_ray_hit regression: pass");
        end else begin
            $display("box_wall_ray_hit regression: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/bwrh_pkg.sv
src/bwrh_if.sv
src/bwrh_front.sv
src/bwrh_fifo.sv
src/bwrh_back.sv
src/box_wall_ray_hit.sv
sim/tb_top.sv
